@@ rtl/pkf_pkg.sv @@
// Shared types, constants and checksum helper for the packet framer.
`timescale 1ns / 1ps

package pkf_pkg;

  // Depth of the command queue between the front and back parts.
  localparam int QDepth = 4;
  localparam int QAddrW = $clog2(QDepth);
  localparam int QCountW = $clog2(QDepth + 1);

  // Mask for the mod 256 sums.
  localparam logic [7:0] ByteMask = 8'hFF;

  // Input item modes.
  localparam logic ModeHeader = 1'b0;
  localparam logic ModePayload = 1'b1;

  // Kind of work that the back part carries out.
  typedef enum logic [1:0] {
    CMD_HDR,
    CMD_PAY,
    CMD_ERR
  } cmd_kind_t;

  // One classified item as it travels through the queue.
  typedef struct packed {
    cmd_kind_t   kind;
    logic        last;
    logic [15:0] preamble;
    logic [15:0] msg_id;
    logic [15:0] msg_len;
    logic [7:0]  data;
    logic [7:0]  sum_a;
    logic [7:0]  sum_b;
  } cmd_t;

  // Beat index within one command.
  typedef logic [2:0] step_t;

  // Fletcher sums over the four header bytes, starting from zero.
  // Returns {sum_b, sum_a}.
  function automatic logic [15:0] hdr_sums(input logic [15:0] id, input logic [15:0] len);
    logic [7:0] bytes [4];
    logic [7:0] a;
    logic [7:0] b;
    bytes[0] = id[7:0];
    bytes[1] = id[15:8];
    bytes[2] = len[7:0];
    bytes[3] = len[15:8];
    a = 8'h00;
    b = 8'h00;
    for (int i = 0; i < 4; i++) begin
      a = (a + bytes[i]) & ByteMask;
      b = (b + a) & ByteMask;
    end
    return {b, a};
  endfunction

endpackage

@@ rtl/pkf_front.sv @@
// Front part: accepts input beats, tracks packet state and sums, builds commands.
`timescale 1ns / 1ps

module pkf_front #(
  parameter int MAX_PAYLOAD = 49
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [15:0]  cfg_wr_data,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic         mode,
  input  logic [15:0]  message_id,
  input  logic [15:0]  payload_length,
  input  logic [7:0]   data_byte,
  output logic         push,
  output pkf_pkg::cmd_t push_cmd,
  input  logic         q_full
);
  import pkf_pkg::*;

  localparam int LenW = $clog2(MAX_PAYLOAD + 1);
  localparam logic [15:0] MaxLen = 16'(MAX_PAYLOAD);

  logic [15:0]     preamble;
  logic [7:0]      sum_a;
  logic [7:0]      sum_b;
  logic [LenW-1:0] bytes_left;
  logic            in_packet;

  logic            accept;
  logic [15:0]     hsum;
  logic [7:0]      pay_a;
  logic [7:0]      pay_b;
  logic            len_bad;
  logic            pay_last;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  // Checksum arithmetic for both kinds of beat.
  assign hsum     = hdr_sums(message_id, payload_length);
  assign pay_a    = sum_a + data_byte;
  assign pay_b    = sum_b + pay_a;
  assign len_bad  = payload_length > MaxLen;
  assign pay_last = bytes_left == LenW'(1);

  // Classify the beat into a command for the back part.
  always_comb begin
    push              = 1'b0;
    push_cmd          = '0;
    push_cmd.preamble = preamble;
    push_cmd.msg_id   = message_id;
    push_cmd.msg_len  = payload_length;
    push_cmd.data     = data_byte;
    if (mode == ModeHeader) begin
      push = accept;
      if (len_bad) begin
        push_cmd.kind = CMD_ERR;
        push_cmd.last = 1'b1;
      end else begin
        push_cmd.kind  = CMD_HDR;
        push_cmd.last  = payload_length == 16'd0;
        push_cmd.sum_a = hsum[7:0];
        push_cmd.sum_b = hsum[15:8];
      end
    end else begin
      // Payload outside a packet is dropped without a command.
      push           = accept && in_packet;
      push_cmd.kind  = CMD_PAY;
      push_cmd.last  = pay_last;
      push_cmd.sum_a = pay_a;
      push_cmd.sum_b = pay_b;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      preamble <= 16'h0000;
    end else if (cfg_wr_en) begin
      preamble <= cfg_wr_data;
    end
  end

  // Packet state and running sums.
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_a      <= 8'h00;
      sum_b      <= 8'h00;
      bytes_left <= '0;
      in_packet  <= 1'b0;
    end else if (accept) begin
      if (mode == ModeHeader) begin
        if (len_bad || payload_length == 16'd0) begin
          sum_a      <= 8'h00;
          sum_b      <= 8'h00;
          bytes_left <= '0;
          in_packet  <= 1'b0;
        end else begin
          sum_a      <= hsum[7:0];
          sum_b      <= hsum[15:8];
          bytes_left <= payload_length[LenW-1:0];
          in_packet  <= 1'b1;
        end
      end else if (in_packet) begin
        sum_a      <= pay_a;
        sum_b      <= pay_b;
        bytes_left <= bytes_left - LenW'(1);
        in_packet  <= !pay_last;
      end
    end
  end

endmodule

@@ rtl/pkf_queue.sv @@
// Short command queue that decouples the front and back parts.
`timescale 1ns / 1ps

module pkf_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pkf_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          q_valid,
  output pkf_pkg::cmd_t q_cmd
);
  import pkf_pkg::*;

  cmd_t              slots [QDepth];
  logic [QAddrW-1:0] wr_ptr;
  logic [QAddrW-1:0] rd_ptr;
  logic [QCountW-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full    = count == QCountW'(QDepth);
  assign q_valid = count != '0;
  assign q_cmd   = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QAddrW'(QDepth - 1)) ? '0 : wr_ptr + QAddrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QAddrW'(QDepth - 1)) ? '0 : rd_ptr + QAddrW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCountW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCountW'(1);
      end
    end
  end

endmodule

@@ rtl/pkf_back.sv @@
// Back part: expands each command into output beats through an output register.
`timescale 1ns / 1ps

module pkf_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  pkf_pkg::cmd_t q_cmd,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_byte,
  output logic          end_of_packet,
  output logic          length_error
);
  import pkf_pkg::*;

  cmd_t       cur;
  logic       cur_valid;
  step_t      step;

  logic       out_free;
  logic       advance;
  logic       last_step;
  step_t      final_step;
  logic [7:0] beat_byte;
  logic       beat_eop;
  logic       beat_err;

  assign out_free  = !out_valid || !out_stall;
  assign advance   = cur_valid && out_free;
  assign last_step = step == final_step;
  assign pop       = q_valid && (!cur_valid || (advance && last_step));

  // Select the byte for the current step of the command.
  always_comb begin
    beat_byte  = 8'h00;
    beat_eop   = 1'b0;
    beat_err   = 1'b0;
    final_step = step_t'(0);
    case (cur.kind)
      CMD_HDR: begin
        final_step = cur.last ? step_t'(7) : step_t'(5);
        case (step)
          3'd0:    beat_byte = cur.preamble[7:0];
          3'd1:    beat_byte = cur.preamble[15:8];
          3'd2:    beat_byte = cur.msg_id[7:0];
          3'd3:    beat_byte = cur.msg_id[15:8];
          3'd4:    beat_byte = cur.msg_len[7:0];
          3'd5:    beat_byte = cur.msg_len[15:8];
          3'd6:    beat_byte = cur.sum_a;
          default: beat_byte = cur.sum_b;
        endcase
        beat_eop = cur.last && step == step_t'(7);
      end
      CMD_PAY: begin
        final_step = cur.last ? step_t'(2) : step_t'(0);
        case (step)
          3'd0:    beat_byte = cur.data;
          3'd1:    beat_byte = cur.sum_a;
          default: beat_byte = cur.sum_b;
        endcase
        beat_eop = cur.last && step == step_t'(2);
      end
      CMD_ERR: begin
        beat_eop = 1'b1;
        beat_err = 1'b1;
      end
      default: begin
        beat_byte = 8'h00;
      end
    endcase
  end

  // Current command and its step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      step      <= '0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      step      <= '0;
    end else if (advance) begin
      if (last_step) begin
        cur_valid <= 1'b0;
      end else begin
        step <= step + step_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_cmd;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte      <= beat_byte;
      end_of_packet <= beat_eop;
      length_error  <= beat_err;
    end
  end

endmodule

@@ rtl/packet_framer_fletcher_checksum.sv @@
// Top level of the packet framer with trailing Fletcher checksum.
`timescale 1ns / 1ps
// Usage:
// The input channel takes one beat per item: mode 0 is a header with message_id and
// payload_length, mode 1 is one payload data_byte. The output channel carries one
// packet byte per beat with end_of_packet and length_error flags. Both channels use
// valid and stall; a beat moves when valid is high and stall is low.
// A header produces six beats (preamble, id, length, each low byte first), or eight
// with the checksum for a zero length packet. A payload byte produces one beat, and
// three on the last byte of the packet (byte, sum a, sum b). A header whose length
// exceeds MAX_PAYLOAD produces one error beat and no packet bytes.
// An item's first beat passes through the command queue, current command register and
// output register. The back part emits one beat per cycle while out_stall is low, so
// payload streams at one byte per cycle; the queue absorbs headers and checksums. The
// preamble register is written through cfg_wr_en and cfg_wr_data; the user must do so
// only while idle, as the block does not enforce it. Synchronous reset clears the
// preamble, packet state, queue and output register. When out_stall is high the
// output beat holds, the back part waits, and in_stall rises once the queue fills.

module packet_framer_fletcher_checksum #(
  parameter int MAX_PAYLOAD = 49
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [15:0] message_id,
  input  logic [15:0] payload_length,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        end_of_packet,
  output logic        length_error
);
  import pkf_pkg::*;

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic pop;
  logic q_valid;
  cmd_t q_cmd;

  pkf_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .mode           (mode),
    .message_id     (message_id),
    .payload_length (payload_length),
    .data_byte      (data_byte),
    .push           (push),
    .push_cmd       (push_cmd),
    .q_full         (q_full)
  );

  pkf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  pkf_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_cmd         (q_cmd),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .end_of_packet (end_of_packet),
    .length_error  (length_error)
  );

endmodule

@@ rtl/pkf_checker.sv @@
// Port-level checks for the packet framer, bound to the top level.
`timescale 1ns / 1ps

module pkf_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       end_of_packet,
  input logic       length_error
);

  // The output register is empty in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output beat present right after reset");

  // An error beat always closes the packet and carries a zero byte.
  a_err_eop: assert property (@(posedge clk) disable iff (rst)
    out_valid && length_error |-> end_of_packet && out_byte == 8'h00)
    else $error("error beat without end_of_packet or with nonzero byte");

  // No output appears just after the first cycle out of reset unless that cycle accepts an input beat.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    $past(rst) && !(in_valid && !in_stall) |=> !out_valid)
    else $error("output beat without any accepted input beat");

  // A stalled output beat holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(end_of_packet)
      && $stable(length_error))
    else $error("stalled output beat changed");

endmodule

bind packet_framer_fletcher_checksum pkf_checker u_pkf_checker (.*);

@@ sim/packet_framer_fletcher_checksum_tb.sv @@
// Testbench for the packet framer: directed and random traffic checked against a checksum predictor.
`timescale 1ns / 1ps

module packet_framer_fletcher_checksum_tb;
  import pkf_pkg::*;

  localparam int MaxPayload = 49;
  localparam int SettleCycles = 10;
  localparam int LongHold = 400;
  localparam int CycleLimit = 150000;
  localparam int PhaseItems = 60;

  // One input beat as queued for the driver.
  typedef struct packed {
    logic        mode;
    logic [15:0] id;
    logic [15:0] len;
    logic [7:0]  data;
  } frame_item_t;

  // One expected output beat.
  typedef struct packed {
    logic [7:0] value;
    logic       eop;
    logic       err;
  } framed_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        mode = ModeHeader;
  logic [15:0] message_id = '0;
  logic [15:0] payload_length = '0;
  logic [7:0]  data_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        end_of_packet;
  logic        length_error;

  frame_item_t  pending_items[$];
  framed_beat_t expected_beats[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_armed = 1'b0;
  int hold_count = 0;
  int fail_count = 0;
  int cycle_count = 0;

  // Predictor state: preamble register, running sums and packet progress.
  logic [15:0] preamble_now = '0;
  logic [7:0]  run_sum_a = '0;
  logic [7:0]  run_sum_b = '0;
  logic [15:0] bytes_owed = '0;
  logic        pkt_open = 1'b0;

  packet_framer_fletcher_checksum #(
    .MAX_PAYLOAD(MaxPayload)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .mode          (mode),
    .message_id    (message_id),
    .payload_length(payload_length),
    .data_byte     (data_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .end_of_packet (end_of_packet),
    .length_error  (length_error)
  );

  always #1 clk = ~clk;

  // Run limit in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic void push_beat(input logic [7:0] value, input logic eop, input logic err);
    framed_beat_t b;
    b.value = value;
    b.eop = eop;
    b.err = err;
    expected_beats.push_back(b);
  endfunction

  function automatic void fletcher_add(input logic [7:0] b);
    run_sum_a = run_sum_a + b;
    run_sum_b = run_sum_b + run_sum_a;
  endfunction

  function automatic void close_packet();
    push_beat(run_sum_a, 1'b0, 1'b0);
    push_beat(run_sum_b, 1'b1, 1'b0);
    pkt_open = 1'b0;
    bytes_owed = '0;
  endfunction

  // Work out the beats that one accepted input item must produce.
  function automatic void predict_framing(input frame_item_t it);
    logic [31:0] hdr;
    if (it.mode == ModeHeader) begin
      pkt_open = 1'b0;
      bytes_owed = '0;
      run_sum_a = '0;
      run_sum_b = '0;
      if (it.len > MaxPayload) begin
        push_beat(8'h00, 1'b1, 1'b1);
      end else begin
        push_beat(preamble_now[7:0], 1'b0, 1'b0);
        push_beat(preamble_now[15:8], 1'b0, 1'b0);
        hdr = {it.len, it.id};
        for (int i = 0; i < 4; i++) begin
          fletcher_add(hdr[8*i +: 8]);
          push_beat(hdr[8*i +: 8], 1'b0, 1'b0);
        end
        if (it.len == 0) begin
          close_packet();
        end else begin
          bytes_owed = it.len;
          pkt_open = 1'b1;
        end
      end
    end else if (pkt_open) begin
      fletcher_add(it.data);
      push_beat(it.data, 1'b0, 1'b0);
      bytes_owed = bytes_owed - 16'd1;
      if (bytes_owed == 0) close_packet();
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch at cycle %0d: %s got 0x%0h expected 0x%0h", cycle_count, what, got, want);
    fail_count++;
  endtask

  // Driver: offers queued items, holds a stalled beat, predicts on acceptance.
  always @(posedge clk) begin
    frame_item_t it;
    frame_item_t cur;
    logic offer;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        cur.mode = mode;
        cur.id = message_id;
        cur.len = payload_length;
        cur.data = data_byte;
        predict_framing(cur);
      end
      offer = pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct;
      if (offer) begin
        it = pending_items.pop_front();
        mode <= it.mode;
        message_id <= it.id;
        payload_length <= it.len;
        data_byte <= it.data;
      end
      in_valid <= offer;
    end
  end

  // Receiver: one long hold-off when armed, otherwise random stalls.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_armed && hold_count < LongHold) begin
      out_stall <= 1'b1;
      hold_count <= hold_count + 1;
    end else begin
      out_stall <= $urandom_range(0, 99) < recv_stall_pct;
    end
  end

  // Monitor: compare every accepted output beat with the oldest expectation.
  always @(posedge clk) begin
    framed_beat_t exp_beat;
    if (!rst && out_valid && !out_stall) begin
      if (expected_beats.size() == 0) begin
        report_mismatch("unexpected beat, out_byte", 16'(out_byte), 16'h0);
      end else begin
        exp_beat = expected_beats.pop_front();
        if (out_byte !== exp_beat.value)
          report_mismatch("out_byte", 16'(out_byte), 16'(exp_beat.value));
        if (end_of_packet !== exp_beat.eop)
          report_mismatch("end_of_packet", 16'(end_of_packet), 16'(exp_beat.eop));
        if (length_error !== exp_beat.err)
          report_mismatch("length_error", 16'(length_error), 16'(exp_beat.err));
      end
    end
  end

  task automatic queue_header(input logic [15:0] id, input logic [15:0] len);
    frame_item_t it;
    it.mode = ModeHeader;
    it.id = id;
    it.len = len;
    it.data = 8'($urandom_range(0, 255));
    pending_items.push_back(it);
  endtask

  task automatic queue_payload(input logic [7:0] data);
    frame_item_t it;
    it.mode = ModePayload;
    it.id = 16'($urandom_range(0, 65535));
    it.len = 16'($urandom_range(0, 65535));
    it.data = data;
    pending_items.push_back(it);
  endtask

  // Mostly complete packets with random content, plus errors, cut-off packets and strays.
  task automatic queue_random_traffic(input int n);
    int count;
    int pick;
    int len;
    int cut;
    bit open;
    count = 0;
    open = 1'b0;
    while (count < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        case ($urandom_range(0, 3))
          0: len = MaxPayload + 1;
          1: len = 16'hFFFF;
          default: len = $urandom_range(MaxPayload + 1, 65535);
        endcase
        queue_header(16'($urandom_range(0, 65535)), 16'(len));
        open = 1'b0;
        count++;
      end else if (pick < 12) begin
        if (!open) queue_payload(8'($urandom_range(0, 255)));
      end else if (pick < 18) begin
        len = $urandom_range(2, 12);
        cut = $urandom_range(1, len - 1);
        queue_header(16'($urandom_range(0, 65535)), 16'(len));
        repeat (cut) queue_payload(8'($urandom_range(0, 255)));
        open = 1'b1;
        count += 1 + cut;
      end else begin
        if (pick < 21) len = MaxPayload;
        else if (pick < 30) len = $urandom_range(9, MaxPayload - 1);
        else len = $urandom_range(0, 8);
        queue_header(16'($urandom_range(0, 65535)), 16'(len));
        repeat (len) queue_payload(8'($urandom_range(0, 255)));
        open = 1'b0;
        count += 1 + len;
      end
    end
  endtask

  // Wait until all items went in and all expected beats came out, then settle.
  task automatic wait_drained();
    while (pending_items.size() > 0 || in_valid || expected_beats.size() > 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_preamble(input logic [15:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    preamble_now = value;
    @(negedge clk);
  endtask

  task automatic run_phase(input logic [15:0] preamble, input int send_pct,
                           input int stall_pct, input bit pressure);
    write_preamble(preamble);
    send_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
    if (pressure) hold_armed = 1'b1;
    queue_random_traffic(PhaseItems);
    wait_drained();
  endtask

  // Stimulus sequence.
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty packets, length limits, strays, dropped packets.
    write_preamble(16'hFFFF);
    queue_header(16'h0000, 16'd0);
    queue_header(16'hFFFF, 16'd0);
    queue_header(16'h1234, 16'(MaxPayload + 1));
    queue_payload(8'hFF);
    queue_header(16'hA55A, 16'hFFFF);
    queue_payload(8'h00);
    queue_header(16'h1234, 16'd1);
    queue_payload(8'hFF);
    queue_header(16'h00FF, 16'd3);
    queue_payload(8'h00);
    queue_header(16'hFF00, 16'd2);
    queue_payload(8'h80);
    queue_payload(8'h7F);
    queue_payload(8'h55);
    queue_header(16'h8001, 16'(MaxPayload));
    repeat (5) queue_payload(8'($urandom_range(0, 255)));
    queue_header(16'h5AA5, 16'd0);
    wait_drained();

    run_phase(16'h0000, 0, 0, 1'b0);
    run_phase(16'($urandom_range(0, 65535)), 74, 0, 1'b0);
    run_phase(16'h8001, 0, 74, 1'b0);
    run_phase(16'($urandom_range(0, 65535)), 15, 15, 1'b0);
    run_phase(16'hFFFF, 0, 0, 1'b1);

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
